[hdl/ftc_pkg.sv]
// Shared types and constants for the ULP-tolerant float compare pipeline.
// Used by every module under hdl; depends on nothing.
package ftc_pkg;

    localparam int unsigned OP_W  = 64;
    localparam int unsigned MAG_W = 63;
    localparam int unsigned TOL_W = 63;
    localparam int unsigned ACT_W = 3;

    localparam logic [22:0] SP_MANT_MASK = 23'((1 << 23) - 1);
    localparam logic [30:0] SP_INF_MAG   = 31'h7F80_0000;
    localparam logic [62:0] DP_INF_MAG   = 63'h7FF0_0000_0000_0000;
    localparam logic [TOL_W-1:0] SP_TOL_MAX  = 63'h0000_0000_7FFF_FFFF;
    localparam logic [TOL_W-1:0] TOL_RESET   = 63'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_EQ = 3'd0,
        ACT_LT = 3'd1,
        ACT_LE = 3'd2,
        ACT_GT = 3'd3,
        ACT_GE = 3'd4
    } t_action;

    typedef struct packed {
        logic              valid;
        logic              nan;
        logic              exact;
        logic              zero;
        logic              sa;
        logic              sb;
        logic [MAG_W-1:0]  ma;
        logic [MAG_W-1:0]  mb;
        logic [TOL_W-1:0]  tol;
        logic [ACT_W-1:0]  act;
    } t_s1;

    typedef struct packed {
        logic              valid;
        logic              nan;
        logic              exact;
        logic              zero;
        logic              sa;
        logic              sb;
        logic              mag_eq;
        logic              mag_lt;
        logic [MAG_W-1:0]  ulp_gap;
        logic [TOL_W-1:0]  tol;
        logic [ACT_W-1:0]  act;
    } t_s2;

endpackage

[hdl/ftc_decode.sv]
// Stage 1: precision select, field split, NaN/infinity/sign-class flags, tolerance clamp.
// Depends on ftc_pkg.
module ftc_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ftc_pkg::OP_W-1:0]   i_operand_a,
    input  logic [ftc_pkg::OP_W-1:0]   i_operand_b,
    input  logic                       i_is_double,
    input  logic [ftc_pkg::ACT_W-1:0]  i_action,
    input  logic [ftc_pkg::TOL_W-1:0]  i_tol,
    output ftc_pkg::t_s1               o_s1
);
    import ftc_pkg::*;

    t_s1  r_s1;
    t_s1  n_s1;
    logic a_inf, b_inf, a_nan, b_nan;

    always_comb begin
        n_s1.valid = i_valid;
        n_s1.act   = i_action;
        if (i_is_double) begin
            n_s1.sa  = i_operand_a[63];
            n_s1.sb  = i_operand_b[63];
            n_s1.ma  = i_operand_a[62:0];
            n_s1.mb  = i_operand_b[62:0];
            n_s1.tol = i_tol;
            a_inf    = i_operand_a[62:0] == DP_INF_MAG;
            b_inf    = i_operand_b[62:0] == DP_INF_MAG;
            a_nan    = (&i_operand_a[62:52]) && (|i_operand_a[51:0]);
            b_nan    = (&i_operand_b[62:52]) && (|i_operand_b[51:0]);
        end else begin
            n_s1.sa  = i_operand_a[31];
            n_s1.sb  = i_operand_b[31];
            n_s1.ma  = {32'd0, i_operand_a[30:0]};
            n_s1.mb  = {32'd0, i_operand_b[30:0]};
            n_s1.tol = (i_tol > SP_TOL_MAX) ? SP_TOL_MAX : i_tol;
            a_inf    = i_operand_a[30:0] == SP_INF_MAG;
            b_inf    = i_operand_b[30:0] == SP_INF_MAG;
            a_nan    = (&i_operand_a[30:23]) && (|(i_operand_a[22:0] & SP_MANT_MASK));
            b_nan    = (&i_operand_b[30:23]) && (|(i_operand_b[22:0] & SP_MANT_MASK));
        end
        n_s1.nan   = a_nan || b_nan;
        n_s1.exact = a_inf || b_inf || (n_s1.sa != n_s1.sb);
        n_s1.zero  = (n_s1.ma == '0) && (n_s1.mb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.nan   <= n_s1.nan;
        r_s1.exact <= n_s1.exact;
        r_s1.zero  <= n_s1.zero;
        r_s1.sa    <= n_s1.sa;
        r_s1.sb    <= n_s1.sb;
        r_s1.ma    <= n_s1.ma;
        r_s1.mb    <= n_s1.mb;
        r_s1.tol   <= n_s1.tol;
        r_s1.act   <= n_s1.act;
    end

    assign o_s1 = r_s1;

endmodule

[hdl/ftc_diff.sv]
// Stage 2: magnitude subtraction in both directions, absolute distance and order.
// Depends on ftc_pkg.
module ftc_diff (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ftc_pkg::t_s1  i_s1,
    output ftc_pkg::t_s2  o_s2
);
    import ftc_pkg::*;

    t_s2            r_s2;
    t_s2            n_s2;
    logic [MAG_W:0] d_ab;
    logic [MAG_W:0] d_ba;

    always_comb begin
        d_ab        = {1'b0, i_s1.ma} - {1'b0, i_s1.mb};
        d_ba        = {1'b0, i_s1.mb} - {1'b0, i_s1.ma};
        n_s2.valid  = i_s1.valid;
        n_s2.nan    = i_s1.nan;
        n_s2.exact  = i_s1.exact;
        n_s2.zero   = i_s1.zero;
        n_s2.sa     = i_s1.sa;
        n_s2.sb     = i_s1.sb;
        n_s2.tol    = i_s1.tol;
        n_s2.act    = i_s1.act;
        n_s2.mag_lt = d_ab[MAG_W];
        n_s2.mag_eq = d_ab == '0;
        n_s2.ulp_gap = d_ab[MAG_W] ? d_ba[MAG_W-1:0] : d_ab[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.nan     <= n_s2.nan;
        r_s2.exact   <= n_s2.exact;
        r_s2.zero    <= n_s2.zero;
        r_s2.sa      <= n_s2.sa;
        r_s2.sb      <= n_s2.sb;
        r_s2.mag_eq  <= n_s2.mag_eq;
        r_s2.mag_lt  <= n_s2.mag_lt;
        r_s2.ulp_gap <= n_s2.ulp_gap;
        r_s2.tol     <= n_s2.tol;
        r_s2.act     <= n_s2.act;
    end

    assign o_s2 = r_s2;

endmodule

[hdl/ftc_decide.sv]
// Stage 3: tolerance compare, exact/tolerant relation and action select into the result register.
// Depends on ftc_pkg.
module ftc_decide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ftc_pkg::t_s2  i_s2,
    output logic          o_valid,
    output logic          o_verdict
);
    import ftc_pkg::*;

    logic r_valid;
    logic r_verdict;
    logic n_verdict;
    logic close, lt, eq, lt_x, gt_x;

    always_comb begin
        close = i_s2.ulp_gap <= i_s2.tol;
        lt    = i_s2.sa ? (!i_s2.mag_lt && !i_s2.mag_eq) : i_s2.mag_lt;
        if (i_s2.zero) begin
            eq   = 1'b1;
            lt_x = 1'b0;
        end else begin
            eq   = (i_s2.sa == i_s2.sb) && i_s2.mag_eq;
            lt_x = (i_s2.sa != i_s2.sb) ? i_s2.sa : lt;
        end
        gt_x = !eq && !lt_x;
        n_verdict = 1'b0;
        if (!i_s2.nan) begin
            if (i_s2.exact) begin
                case (t_action'(i_s2.act))
                    ACT_EQ:  n_verdict = eq;
                    ACT_LT:  n_verdict = lt_x;
                    ACT_LE:  n_verdict = lt_x || eq;
                    ACT_GT:  n_verdict = gt_x;
                    ACT_GE:  n_verdict = gt_x || eq;
                    default: n_verdict = 1'b0;
                endcase
            end else begin
                case (t_action'(i_s2.act))
                    ACT_EQ:  n_verdict = close;
                    ACT_LT:  n_verdict = !close && lt;
                    ACT_LE:  n_verdict = close || lt;
                    ACT_GT:  n_verdict = !close && !lt;
                    ACT_GE:  n_verdict = close || !lt;
                    default: n_verdict = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
        r_verdict <= n_verdict;
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

[hdl/float_ulp_tolerance_compare.sv]
// Top level of the ULP-tolerant float compare: APB tolerance register and three-stage pipeline.
// Depends on ftc_pkg, ftc_decode, ftc_diff and ftc_decide.
//
// One item is taken every clock cycle; busy stays low. The verdict for an item shows on
// o_verdict with o_verdict_valid high for one cycle, after the item has passed the decode,
// subtract and decide register stages in that order. Results come out in item order and the
// receiver cannot stall them. Write ulp_tolerance at byte address 0 (64-bit data, bit 63
// ignored) only while no items are in flight.
module float_ulp_tolerance_compare (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ftc_pkg::OP_W-1:0]   i_operand_a,
    input  logic [ftc_pkg::OP_W-1:0]   i_operand_b,
    input  logic                       i_is_double,
    input  logic [ftc_pkg::ACT_W-1:0]  i_action,
    output logic                       o_verdict_valid,
    output logic                       o_verdict,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import ftc_pkg::*;

    logic [TOL_W-1:0] r_tol;
    logic             cfg_wr;
    t_s1              s1;
    t_s2              s2;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : {1'b0, r_tol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (cfg_wr) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    ftc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_is_double (i_is_double),
        .i_action    (i_action),
        .i_tol       (r_tol),
        .o_s1        (s1)
    );

    ftc_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    ftc_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s2      (s2),
        .o_valid   (o_verdict_valid),
        .o_verdict (o_verdict)
    );

endmodule
